// ===== src/ssq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and codes for the stable sorted priority queue
// Action and status codes, field widths of the item channels and the
// result struct of the slot compare unit.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int ACTION_W  = 2;
    localparam int ID_IN_W   = 8;
    localparam int RANK_IN_W = 32;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 5;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_POP    = 2'd1;
    localparam t_action ACT_REMOVE = 2'd2;
    localparam t_action ACT_NOP    = 2'd3;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_EMPTY   = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_MISSING = 3'd3;
    localparam t_status ST_DUP     = 3'd4;

    // Result of comparing one stored slot against the key of the current item
    typedef struct packed {
        logic id_eq;
        logic rank_le;
    } t_cmp;

endpackage

// ===== src/ssq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_req_if: request channel of the sorted priority queue
// Valid/ready handshake carrying one queue operation per item.
// ----------------------------------------------------------------------------
interface ssq_req_if;
    import ssq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [ID_IN_W-1:0]   member_id;
    logic [RANK_IN_W-1:0] rank;

    modport source (output valid, output action, output member_id, output rank,
                    input ready);
    modport sink   (input valid, input action, input member_id, input rank,
                    output ready);
endinterface

// ===== src/ssq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_rsp_if: response channel of the sorted priority queue
// Valid/ready handshake carrying one result item per operation.
// ----------------------------------------------------------------------------
interface ssq_rsp_if;
    import ssq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ID_IN_W-1:0]   out_member_id;
    logic [RANK_IN_W-1:0] out_rank;
    logic [OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output out_member_id,
                    output out_rank, output occupancy, input ready);
    modport sink   (input valid, input status, input out_member_id,
                    input out_rank, input occupancy, output ready);
endinterface

// ===== src/ssq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_ram: slot storage
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/ssq_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cmp: slot compare unit
// Compares one slot read from storage with the id and rank of the item.
// ----------------------------------------------------------------------------
module ssq_cmp #(
    parameter int ID_BITS   = 8,
    parameter int RANK_BITS = 32
) (
    input  logic [ID_BITS-1:0]   i_key_id,
    input  logic [RANK_BITS-1:0] i_key_rank,
    input  logic [ID_BITS-1:0]   i_slot_id,
    input  logic [RANK_BITS-1:0] i_slot_rank,
    output ssq_pkg::t_cmp        o_cmp
);
    import ssq_pkg::*;

    always_comb begin
        o_cmp.id_eq   = (i_slot_id == i_key_id);
        o_cmp.rank_le = (i_slot_rank <= i_key_rank);
    end
endmodule

// ===== src/stable_sorted_priority_queue.sv =====
// Sequence: insert scans for its place, then shifts the later entries up;
//   pop and remove scan, then shift down to close the gap; a duplicate, full or
//   missing id ends after the scan; a no-op and a pop or remove on an empty queue go straight to the result.
// Throughput: one item at a time; the slot memory port is walked one slot per
//   cycle for the search and again for the shift that opens or closes a gap.
//   Ready returns when the result is loaded; a held result stalls.
// Reset: synchronous active-low; the queue comes up empty, no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: stable sorted queue with removal
// Entries sit in rank order in a slot memory. A small sequencer scans the
// slots through one compare unit, then shifts entries to insert or remove.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
    parameter int CAPACITY  = 16,
    parameter int RANK_BITS = 32,
    parameter int ID_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssq_req_if.sink     i_req,
    ssq_rsp_if.source   o_rsp
);
    import ssq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = ID_BITS + RANK_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    t_action              r_act;
    logic [ID_BITS-1:0]   r_id;
    logic [RANK_BITS-1:0] r_rank;
    logic [CNT_W-1:0]     r_scan;
    logic [CNT_W-1:0]     r_pos;
    logic                 r_pos_set;
    logic                 r_dup;
    logic                 r_pv;
    logic [IDX_W-1:0]     r_pidx;
    t_status              r_status;
    logic [ID_BITS-1:0]   r_res_id;
    logic [RANK_BITS-1:0] r_res_rank;
    logic                 r_out_vld;
    t_status              r_out_status;
    logic [ID_IN_W-1:0]   r_out_id;
    logic [RANK_IN_W-1:0] r_out_rank;
    logic [OCC_W-1:0]     r_out_occ;

    logic                 w_issue;
    logic [IDX_W-1:0]     w_raddr;
    logic [CNT_W-1:0]     w_scan_m1;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [ENT_W-1:0]     w_wdata;
    logic [ENT_W-1:0]     w_rdata;
    logic [ID_BITS-1:0]   w_slot_id;
    logic [RANK_BITS-1:0] w_slot_rank;
    t_cmp                 w_cmp;
    logic                 w_accept;
    logic                 w_take;

    ssq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_slot_id   = w_rdata[ENT_W-1:RANK_BITS];
    assign w_slot_rank = w_rdata[RANK_BITS-1:0];

    ssq_cmp #(
        .ID_BITS   (ID_BITS),
        .RANK_BITS (RANK_BITS)
    ) u_cmp (
        .i_key_id    (r_id),
        .i_key_rank  (r_rank),
        .i_slot_id   (w_slot_id),
        .i_slot_rank (w_slot_rank),
        .o_cmp       (w_cmp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_scan_m1   = r_scan - 1'b1;

    // slot to take out found during the scan; drop the read in flight
    assign w_take = (r_state == S_SCAN) && r_pv &&
                    ((r_act == ACT_POP && r_pidx == '0) ||
                     (r_act == ACT_REMOVE && w_cmp.id_eq));

    // Read issue and slot writes; a read's data lands in the next cycle, flagged by r_pv
    always_comb begin
        w_issue = 1'b0;
        w_raddr = r_scan[IDX_W-1:0];
        w_we    = 1'b0;
        w_waddr = r_pidx;
        w_wdata = w_rdata;
        case (r_state)
            S_SCAN: begin
                w_issue = (r_scan < r_count);
            end
            S_SHIFT_DN: begin
                // close the gap: slot i+1 moves to slot i
                w_issue = (r_scan < r_count);
                w_we    = r_pv;
                w_waddr = r_pidx - 1'b1;
            end
            S_SHIFT_UP: begin
                // open the gap from the back: slot i moves to slot i+1
                w_issue = (r_scan > r_pos);
                w_raddr = w_scan_m1[IDX_W-1:0];
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = r_pidx + 1'b1;
                end else if (!w_issue) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[IDX_W-1:0];
                    w_wdata = {r_id, r_rank};
                end
            end
            default: begin
                w_issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_FINISH) begin
                r_out_vld <= 1'b0;
            end
            r_pv <= w_issue && !w_take;
            if (w_issue && !w_take) begin
                r_pidx <= w_raddr;
                r_scan <= (r_state == S_SHIFT_UP) ? w_scan_m1 : r_scan + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_act      <= i_req.action;
                        r_id       <= ID_BITS'(i_req.member_id);
                        r_rank     <= RANK_BITS'(i_req.rank);
                        r_res_id   <= '0;
                        r_res_rank <= '0;
                        r_dup      <= 1'b0;
                        r_pos      <= r_count;
                        r_pos_set  <= 1'b0;
                        r_scan     <= '0;
                        r_status   <= ST_OK;
                        case (i_req.action)
                            ACT_INSERT: begin
                                r_state <= (r_count == '0) ? S_SHIFT_UP : S_SCAN;
                            end
                            ACT_POP: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_state  <= S_SCAN;
                                end
                            end
                            ACT_REMOVE: begin
                                if (r_count == '0) begin
                                    r_status <= ST_MISSING;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_state  <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_pv) begin
                        if (r_act == ACT_INSERT) begin
                            if (w_cmp.id_eq) begin
                                r_dup <= 1'b1;
                            end
                            // first slot ranked strictly later is the insert point
                            if (!w_cmp.rank_le && !r_pos_set) begin
                                r_pos     <= CNT_W'(r_pidx);
                                r_pos_set <= 1'b1;
                            end
                        end else if (w_take) begin
                            r_res_id   <= w_slot_id;
                            r_res_rank <= w_slot_rank;
                            r_scan     <= CNT_W'(r_pidx) + 1'b1;
                            r_state    <= S_SHIFT_DN;
                        end
                    end else if (!w_issue) begin
                        if (r_act == ACT_INSERT) begin
                            if (r_dup) begin
                                r_status <= ST_DUP;
                                r_state  <= S_FINISH;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_FINISH;
                            end else begin
                                r_scan   <= r_count;
                                r_state  <= S_SHIFT_UP;
                            end
                        end else begin
                            r_status <= ST_MISSING;
                            r_state  <= S_FINISH;
                        end
                    end
                end
                S_SHIFT_DN: begin
                    if (!r_pv && !w_issue) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_FINISH;
                    end
                end
                S_SHIFT_UP: begin
                    // the new entry is written in the last cycle
                    if (!r_pv && !w_issue) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_status;
                        r_out_id     <= ID_IN_W'(r_res_id);
                        r_out_rank   <= RANK_IN_W'(r_res_rank);
                        r_out_occ    <= OCC_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.out_member_id = r_out_id;
    assign o_rsp.out_rank      = r_out_rank;
    assign o_rsp.occupancy     = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == $past(r_count) + 1'b1) ||
                           (r_count + 1'b1 == $past(r_count)))
        else $error("entry count moved by more than one");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CNT_W'(w_waddr) <= r_count))
        else $error("slot write beyond the occupied range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
            (o_rsp.out_member_id == '0 && o_rsp.out_rank == '0))
        else $error("error result carries a member");
endmodule
